### hdl/spnr_pkg.sv
`default_nettype none

package spnr_pkg;

  localparam int CFG_DATA_W = 14;
  localparam int WLEN_W     = 7;
  localparam int PCT_W      = 14;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
  localparam logic [PCT_W-1:0]  PCT_RESET  = 14'd5000;

  // floor(v / 10000) as (v * RANK_RECIP) >> RANK_SHIFT, exact for v below 2**26
  localparam int                  RANK_SHIFT = 40;
  localparam int                  RECIP_W    = 27;
  localparam logic [RECIP_W-1:0]  RANK_RECIP = 27'd109951163;

  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_RANK_PCT      = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_REVISE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CMD_HOLD        = 3'd0,
    CMD_MARK_PUSH   = 3'd1,
    CMD_MARK_REVISE = 3'd2,
    CMD_SHIFT       = 3'd3,
    CMD_INSERT      = 3'd4
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      occupied;
    logic      shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/spnr_if.sv
`default_nettype none

interface spnr_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface spnr_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           value_valid;
  logic signed [SAMPLE_WIDTH-1:0] value;

  modport source (output valid, output value_valid, output value, input ready);
  modport sink   (input valid, input value_valid, input value, output ready);
endinterface

interface spnr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic                            addr;
  logic [spnr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### hdl/spnr_cell.sv
`default_nettype none

module spnr_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AGE_W        = 6,
  parameter int CNT_W        = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  spnr_pkg::cell_ctl_t          ctl_i,
  input  wire logic [CNT_W-1:0]        keep_i,
  input  wire logic [SAMPLE_WIDTH-1:0] new_sample_i,
  input  wire logic                    left_gt_i,
  input  wire logic [SAMPLE_WIDTH-1:0] left_sample_i,
  input  wire logic [AGE_W-1:0]        left_age_i,
  input  wire logic [SAMPLE_WIDTH-1:0] right_sample_i,
  input  wire logic [AGE_W-1:0]        right_age_i,
  input  wire logic                    right_evict_i,
  output logic                         gt_o,
  output logic [SAMPLE_WIDTH-1:0]      sample_o,
  output logic [AGE_W-1:0]             age_o,
  output logic                         evict_o
);

  logic [SAMPLE_WIDTH-1:0] sample_q, sample_d;
  logic [AGE_W-1:0]        age_q, age_d;
  logic                    evict_q, evict_d;

  // empty cells count as above any new sample
  assign gt_o     = !ctl_i.occupied || ($signed(sample_q) > $signed(new_sample_i));
  assign sample_o = sample_q;
  assign age_o    = age_q;
  assign evict_o  = evict_q;

  always_comb begin
    sample_d = sample_q;
    age_d    = age_q;
    evict_d  = evict_q;
    unique case (ctl_i.cmd)
      spnr_pkg::CMD_MARK_PUSH: begin
        evict_d = 1'b0;
        if (ctl_i.occupied) begin
          if (CNT_W'(age_q) >= keep_i) begin
            evict_d = 1'b1;
          end else begin
            age_d = age_q + AGE_W'(1);
          end
        end
      end
      spnr_pkg::CMD_MARK_REVISE: begin
        evict_d = ctl_i.occupied && (age_q == '0);
      end
      spnr_pkg::CMD_SHIFT: begin
        if (ctl_i.shift) begin
          sample_d = right_sample_i;
          age_d    = right_age_i;
          evict_d  = right_evict_i;
        end
      end
      spnr_pkg::CMD_INSERT: begin
        evict_d = 1'b0;
        if (gt_o) begin
          if (left_gt_i) begin
            sample_d = left_sample_i;
            age_d    = left_age_i;
          end else begin
            sample_d = new_sample_i;
            age_d    = '0;
          end
        end
      end
      default: begin
        sample_d = sample_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evict_q <= 1'b0;
    end else begin
      evict_q <= evict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    age_q    <= age_d;
  end

endmodule

`default_nettype wire

### hdl/sliding_percentile_nearest_rank.sv
// Sliding-window percentile, nearest rank. The last window_length samples sit in a row of
// cells kept in ascending signed order, each tagged with its age. A push item drops every
// sample that falls out of the window and inserts the new one; a revise item replaces the
// newest sample. Once the window is full each item gives value_valid = 1 and the sorted
// element at ceil(rank_percent_x100 * N / 10000) - 1, clamped to 0..N - 1; before that
// value_valid = 0 and value = 0. One item is worked on at a time: a mark step, shift steps
// that drop one sample per cycle along the cell row until none is left (one in steady
// state, up to the old fill after the window was shrunk), one insert step, two multiplier
// steps for the rank index and the select step. The input is ready again in the same cycle
// in which the result is presented, and a held result stalls the following item in the
// select step.
// Configuration writes are taken at any time but must only be made while the block is idle.
`default_nettype none

module sliding_percentile_nearest_rank #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  spnr_in_if.sink      in_if,
  spnr_out_if.source   out_if,
  spnr_cfg_if.sink     cfg_if
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (CNT_W > spnr_pkg::WLEN_W) ? CNT_W : spnr_pkg::WLEN_W;
  localparam int X_W   = spnr_pkg::PCT_W + CNT_W;
  localparam int P_W   = X_W + spnr_pkg::RECIP_W;
  localparam int Q_W   = P_W - spnr_pkg::RANK_SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_SHIFT,
    ST_INSERT,
    ST_MUL1,
    ST_MUL2,
    ST_SEL
  } state_e;

  state_e                       state_q;
  logic [CNT_W-1:0]             fill_q;
  logic                         op_q;
  logic [SAMPLE_WIDTH-1:0]      new_q;
  logic [X_W-1:0]               x_q;
  logic [P_W-1:0]               prod_q;
  logic                         out_valid_q;
  logic                         value_valid_q;
  logic [SAMPLE_WIDTH-1:0]      value_q;
  logic [spnr_pkg::WLEN_W-1:0]  wlen_q;
  logic [spnr_pkg::PCT_W-1:0]   pct_q;

  spnr_pkg::cell_cmd_e          cmd;
  logic [CNT_W-1:0]             eff_len;
  logic [CNT_W-1:0]             keep;
  logic [CMP_W-1:0]             wlen_ext;
  logic                         any_evict;
  logic                         full;
  logic                         out_free;
  logic [X_W-1:0]               x_m1;
  logic [Q_W-1:0]               quot;
  logic [CNT_W-1:0]             last_pos;
  logic [AGE_W-1:0]             sel_idx;

  logic [MAX_WINDOW-1:0]        gt;
  logic [MAX_WINDOW-1:0]        evict;
  logic [MAX_WINDOW-1:0]        pref;
  logic [SAMPLE_WIDTH-1:0]      cell_sample [MAX_WINDOW];
  logic [AGE_W-1:0]             cell_age    [MAX_WINDOW];

  // window length clamped to 1..MAX_WINDOW
  assign wlen_ext = CMP_W'(wlen_q);
  always_comb begin
    priority if (wlen_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = wlen_ext[CNT_W-1:0];
    end
  end
  assign keep = eff_len - CNT_W'(1);

  assign any_evict = |evict;
  assign full      = (fill_q >= eff_len);
  assign out_free  = !out_valid_q || out_if.ready;

  always_comb begin
    unique case (state_q)
      ST_MARK:   cmd = (op_q == spnr_pkg::OP_PUSH) ? spnr_pkg::CMD_MARK_PUSH
                                                   : spnr_pkg::CMD_MARK_REVISE;
      ST_SHIFT:  cmd = any_evict ? spnr_pkg::CMD_SHIFT : spnr_pkg::CMD_HOLD;
      ST_INSERT: cmd = spnr_pkg::CMD_INSERT;
      default:   cmd = spnr_pkg::CMD_HOLD;
    endcase
  end

  // rank index: floor((x - 1) / 10000) clamped to fill - 1
  assign x_m1     = (x_q == '0) ? '0 : (x_q - X_W'(1));
  assign quot     = prod_q[P_W-1:spnr_pkg::RANK_SHIFT];
  assign last_pos = fill_q - CNT_W'(1);
  assign sel_idx  = (P_W'(quot) > P_W'(last_pos)) ? last_pos[AGE_W-1:0] : quot[AGE_W-1:0];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    spnr_pkg::cell_ctl_t     ctl;
    logic                    left_gt;
    logic [SAMPLE_WIDTH-1:0] left_sample;
    logic [AGE_W-1:0]        left_age;
    logic [SAMPLE_WIDTH-1:0] right_sample;
    logic [AGE_W-1:0]        right_age;
    logic                    right_evict;

    assign pref[i]      = |evict[i:0];
    assign ctl.cmd      = cmd;
    assign ctl.occupied = (CNT_W'(i) < fill_q);
    assign ctl.shift    = pref[i];

    if (i == 0) begin : g_first
      assign left_gt     = 1'b0;
      assign left_sample = new_q;
      assign left_age    = '0;
    end else begin : g_mid
      assign left_gt     = gt[i-1];
      assign left_sample = cell_sample[i-1];
      assign left_age    = cell_age[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_sample = new_q;
      assign right_age    = '0;
      assign right_evict  = 1'b0;
    end else begin : g_inner
      assign right_sample = cell_sample[i+1];
      assign right_age    = cell_age[i+1];
      assign right_evict  = evict[i+1];
    end

    spnr_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W),
      .CNT_W        (CNT_W)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl),
      .keep_i         (keep),
      .new_sample_i   (new_q),
      .left_gt_i      (left_gt),
      .left_sample_i  (left_sample),
      .left_age_i     (left_age),
      .right_sample_i (right_sample),
      .right_age_i    (right_age),
      .right_evict_i  (right_evict),
      .gt_o           (gt[i]),
      .sample_o       (cell_sample[i]),
      .age_o          (cell_age[i]),
      .evict_o        (evict[i])
    );
  end

  assign in_if.ready      = (state_q == ST_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.value_valid = value_valid_q;
  assign out_if.value     = value_q;
  assign cfg_if.ready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= spnr_pkg::WLEN_RESET;
      pct_q  <= spnr_pkg::PCT_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.addr)
        spnr_pkg::REG_WINDOW_LENGTH: wlen_q <= cfg_if.data[spnr_pkg::WLEN_W-1:0];
        spnr_pkg::REG_RANK_PCT:      pct_q  <= cfg_if.data[spnr_pkg::PCT_W-1:0];
        default:                     pct_q  <= pct_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
      op_q          <= 1'b0;
      new_q         <= '0;
      x_q           <= '0;
      prod_q        <= '0;
      value_valid_q <= 1'b0;
      value_q       <= '0;
    end else begin
      if (out_valid_q && out_if.ready && (state_q != ST_SEL)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            op_q    <= in_if.op;
            new_q   <= in_if.sample;
            state_q <= ST_MARK;
          end
        end
        ST_MARK: begin
          state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (any_evict) begin
            fill_q <= fill_q - CNT_W'(1);
          end else begin
            state_q <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          fill_q  <= fill_q + CNT_W'(1);
          state_q <= ST_MUL1;
        end
        ST_MUL1: begin
          x_q     <= X_W'(pct_q) * X_W'(fill_q);
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          prod_q  <= P_W'(x_m1) * P_W'(spnr_pkg::RANK_RECIP);
          state_q <= ST_SEL;
        end
        ST_SEL: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            value_valid_q <= full;
            value_q       <= full ? cell_sample[sel_idx] : '0;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/spnr_checker.sv
`default_nettype none

module spnr_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic                    out_value_valid_i,
  input wire logic [SAMPLE_WIDTH-1:0] out_value_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
                                    && $stable(out_value_valid_i))
    else $error("result dropped or changed while stalled");

  // a result from an unfilled window carries zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_value_valid_i |-> out_value_i == '0)
    else $error("unfilled window result not zero");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in work");

  // a new result needs the earlier one taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> ##1 !$rose(out_valid_i))
    else $error("result overwritten");

endmodule

bind sliding_percentile_nearest_rank spnr_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_spnr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_value_valid_i (out_if.value_valid),
  .out_value_i       (out_if.value)
);

`default_nettype wire

### tb/sliding_percentile_nearest_rank_tb.sv
`default_nettype none

module sliding_percentile_nearest_rank_tb;

  localparam int MAX_WIN   = 64;
  localparam int SMP_W     = 32;
  localparam int N_RANDOM  = 1100;
  localparam int HOLD_LEN  = 400;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    spnr_pkg::op_e     op;
    logic [SMP_W-1:0]  smp;
    logic [13:0]       wlen_d;
    logic [13:0]       pct_d;
    logic              typed;
    logic              exp_valid;
    logic [SMP_W-1:0]  exp_value;
  } row_t;

  typedef struct packed {
    logic             valid;
    logic [SMP_W-1:0] value;
  } pct_result_t;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    int unsigned             age;
  } cell_t;

  // directed stimulus, typed results where obvious
  localparam row_t DIR_TAB [27] = '{
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_0000, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_REVISE, 32'h0000_0005, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h8000_0000, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h7FFF_FFFF, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_CFG,  spnr_pkg::OP_PUSH,   32'h0000_0000, 14'd1,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h7FFF_FFFF, 14'd0,    14'd0,     1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h8000_0000, 14'd0,    14'd0,     1'b1, 1'b1, 32'h8000_0000},
    '{ROW_ITEM, spnr_pkg::OP_REVISE, 32'h0000_3039, 14'd0,    14'd0,     1'b1, 1'b1, 32'h0000_3039},
    '{ROW_CFG,  spnr_pkg::OP_PUSH,   32'h0000_0000, 14'h3F80, 14'h3FFF,  1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'hFFFF_FFF9, 14'd0,    14'd0,     1'b1, 1'b1, 32'hFFFF_FFF9},
    '{ROW_CFG,  spnr_pkg::OP_PUSH,   32'h0000_0000, 14'd3,    14'd10000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_000A, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'hFFFF_FFEC, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_001E, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_REVISE, 32'hFFFF_FFD8, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_0000, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CFG,  spnr_pkg::OP_PUSH,   32'h0000_0000, 14'd5,    14'd5000,  1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_0001, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_0002, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_REVISE, 32'h0000_0002, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CFG,  spnr_pkg::OP_PUSH,   32'h0000_0000, 14'd2,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_REVISE, 32'h0000_0064, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_0032, 14'd0,    14'd0,     1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CFG,  spnr_pkg::OP_PUSH,   32'h0000_0000, 14'h0040, 14'd5461,  1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h0000_0009, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_PUSH,   32'h5555_5555, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, spnr_pkg::OP_REVISE, 32'hAAAA_AAAA, 14'd0,    14'd0,     1'b1, 1'b0, 32'h0000_0000}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  spnr_in_if  #(.SAMPLE_WIDTH(SMP_W)) in_ch ();
  spnr_out_if #(.SAMPLE_WIDTH(SMP_W)) out_ch ();
  spnr_cfg_if                         cfg_ch ();

  sliding_percentile_nearest_rank #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_WIDTH(SMP_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // window tracker state
  logic [6:0]  wlen_reg;
  logic [13:0] pct_reg;
  cell_t       win_q[$];

  pct_result_t pending_pct_q[$];
  pct_result_t want;
  int          mismatch_cnt;
  int          results_seen;
  int          burst_left;
  int          gap;
  int          hold_left;
  bit          hold_done;
  int          seg_left;
  int          seg_mode;

  function automatic int unsigned eff_window();
    int unsigned w;
    w = 32'(wlen_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIN) w = MAX_WIN;
    return w;
  endfunction

  function automatic void insert_sorted(logic signed [SMP_W-1:0] s);
    cell_t       c;
    int unsigned pos;
    pos = 0;
    while (pos < win_q.size() && win_q[pos].smp <= s) pos++;
    c.smp = s;
    c.age = 0;
    win_q.insert(pos, c);
  endfunction

  function automatic void push_sample(logic signed [SMP_W-1:0] s);
    cell_t       kept[$];
    cell_t       c;
    int unsigned keep;
    keep = eff_window() - 1;
    foreach (win_q[i]) begin
      if (win_q[i].age < keep) begin
        c = win_q[i];
        c.age++;
        kept = {kept, c};
      end
    end
    win_q = kept;
    insert_sorted(s);
  endfunction

  function automatic pct_result_t track_window(spnr_pkg::op_e op,
                                               logic signed [SMP_W-1:0] s);
    pct_result_t     r;
    longint unsigned n;
    longint unsigned idx;
    if (op == spnr_pkg::OP_PUSH || win_q.size() == 0) begin
      push_sample(s);
    end else begin
      foreach (win_q[i]) begin
        if (win_q[i].age == 0) begin
          win_q.delete(i);
          break;
        end
      end
      insert_sorted(s);
    end
    r = '0;
    n = win_q.size();
    if (n == 0 || n < eff_window()) return r;
    idx = (64'(pct_reg) * n + 64'd9999) / 64'd10000;
    if (idx > 0) idx--;
    if (idx > n - 1) idx = n - 1;
    r.valid = 1'b1;
    r.value = win_q[idx].smp;
    return r;
  endfunction

  task automatic offer_item(input spnr_pkg::op_e op, input logic [SMP_W-1:0] s,
                            input logic typed, input logic tv,
                            input logic [SMP_W-1:0] tval);
    pct_result_t r;
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.sample <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    r = track_window(op, s);
    if (typed) begin
      r.valid = tv;
      r.value = tval;
    end
    pending_pct_q = {pending_pct_q, r};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(0, 24));
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // only while idle: every pending result has come back
  task automatic apply_config(input logic [13:0] wlen_d, input logic [13:0] pct_d);
    in_ch.valid <= 1'b0;
    while (pending_pct_q.size() != 0) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= spnr_pkg::REG_WINDOW_LENGTH;
    cfg_ch.data  <= wlen_d;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    wlen_reg = wlen_d[6:0];
    cfg_ch.addr <= spnr_pkg::REG_RANK_PCT;
    cfg_ch.data <= pct_d;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    pct_reg = pct_d;
    cfg_ch.valid <= 1'b0;
  endtask

  // result check and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_pct_q.size() == 0) begin
        $error("unexpected item: value_valid %0b value %0d", out_ch.value_valid, out_ch.value);
        mismatch_cnt++;
      end else begin
        want = pending_pct_q[0];
        pending_pct_q.delete(0);
        if (want.valid !== out_ch.value_valid) begin
          $error("value_valid: expected %0b, got %0b", want.valid, out_ch.value_valid);
          mismatch_cnt++;
        end
        if (want.value !== out_ch.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), out_ch.value);
          mismatch_cnt++;
        end
      end
    end
    if (!hold_done && results_seen >= HOLD_LEN && in_ch.valid) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = int'($urandom_range(0, 9));
        seg_left = int'($urandom_range(8, 80));
      end else begin
        seg_left--;
      end
      case (seg_mode)
        0, 1, 2, 3: out_ch.ready <= 1'b1;
        4, 5, 6:    out_ch.ready <= 1'($urandom_range(0, 1));
        7, 8:       out_ch.ready <= ($urandom_range(0, 5) == 0);
        default:    out_ch.ready <= 1'b0;
      endcase
    end
  end

  initial begin
    logic [SMP_W-1:0] smp;
    logic [13:0]      wlen_d;
    logic [13:0]      pct_d;
    spnr_pkg::op_e    op;
    int               total;
    int               n_items;
    bit               dup_heavy;

    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = spnr_pkg::OP_PUSH;
    in_ch.sample  = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = spnr_pkg::REG_WINDOW_LENGTH;
    cfg_ch.data   = '0;
    wlen_reg      = spnr_pkg::WLEN_RESET;
    pct_reg       = spnr_pkg::PCT_RESET;
    mismatch_cnt  = 0;
    results_seen  = 0;
    burst_left    = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    seg_left      = 0;
    seg_mode      = 0;
    total         = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        apply_config(DIR_TAB[i].wlen_d, DIR_TAB[i].pct_d);
      end else begin
        offer_item(DIR_TAB[i].op, DIR_TAB[i].smp, DIR_TAB[i].typed,
                   DIR_TAB[i].exp_valid, DIR_TAB[i].exp_value);
      end
    end

    while (total < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0:       wlen_d = 14'd1;
        1:       wlen_d = 14'd64;
        2:       wlen_d = 14'($urandom_range(0, 16383));
        3:       wlen_d = 14'd0;
        4, 5, 6: wlen_d = 14'($urandom_range(2, 8));
        7, 8:    wlen_d = 14'($urandom_range(9, 32));
        default: wlen_d = 14'($urandom_range(33, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       pct_d = 14'd0;
        1:       pct_d = 14'd10000;
        2:       pct_d = 14'($urandom_range(0, 16383));
        3:       pct_d = 14'd1;
        default: pct_d = 14'($urandom_range(0, 10000));
      endcase
      apply_config(wlen_d, pct_d);
      n_items   = int'(eff_window()) + int'($urandom_range(10, 80));
      dup_heavy = ($urandom_range(0, 2) == 0);
      repeat (n_items) begin
        op = ($urandom_range(0, 4) == 0) ? spnr_pkg::OP_REVISE : spnr_pkg::OP_PUSH;
        case ($urandom_range(0, 9))
          0:       smp = 32'h8000_0000;
          1:       smp = 32'h7FFF_FFFF;
          2, 3, 4: smp = $urandom;
          default: smp = dup_heavy ? 32'($urandom_range(0, 8)) - 32'd4 : $urandom;
        endcase
        offer_item(op, smp, 1'b0, 1'b0, '0);
        total++;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_pct_q.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_WIN + 16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("sliding_percentile_nearest_rank test passed");
    end else begin
      $display("sliding_percentile_nearest_rank test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("sliding_percentile_nearest_rank test failed");
    $finish;
  end

endmodule

`default_nettype wire
